### src/lec_pkg.sv
// ----------------------------------------------------------------------------
// lec_pkg
// Shared constants, types and codes of the LMS echo canceller.
// ----------------------------------------------------------------------------
package lec_pkg;

  localparam int LEC_TAPS     = 1024;
  localparam int LEC_ADDR_W   = $clog2(LEC_TAPS);
  localparam int LEC_SAMPLE_W = 16;
  localparam int LEC_COEF_W   = 32;
  localparam int LEC_STEP_W   = 16;

  localparam logic [LEC_ADDR_W-1:0] LEC_LAST_TAP = LEC_ADDR_W'(LEC_TAPS - 1);

  // configuration port
  localparam int LEC_DATA_W  = 32;
  localparam int LEC_PADDR_W = 3;
  localparam logic LEC_REG_STEP = 1'b0;   // register index, paddr[2]
  localparam logic [LEC_STEP_W-1:0] LEC_STEP_RESET = LEC_STEP_W'(66);

  typedef enum logic [3:0] {
    LEC_CLEAR,
    LEC_IDLE,
    LEC_EST,
    LEC_EST_WAIT,
    LEC_RND,
    LEC_ERR,
    LEC_MU,
    LEC_UPD,
    LEC_UPD_WAIT
  } lec_state_t;

  typedef struct packed {
    logic                  clear;   // zero both stores at tap
    logic                  load;    // write reference at slot, latch mic
    logic                  est_rd;  // read tap/slot for the estimate
    logic                  upd_rd;  // read tap/slot for the update
    logic                  rnd;     // round accumulator to estimate
    logic                  err;     // form saturated error
    logic                  mu;      // form step * error
    logic [LEC_ADDR_W-1:0] tap;
    logic [LEC_ADDR_W-1:0] slot;
  } lec_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } lec_stat_t;

endpackage

### src/lec_in_if.sv
// ----------------------------------------------------------------------------
// lec_in_if
// Request channel: one reference sample and one microphone sample.
// ----------------------------------------------------------------------------
interface lec_in_if;
  import lec_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [LEC_SAMPLE_W-1:0] reference_sample;
  logic signed [LEC_SAMPLE_W-1:0] mic_sample;

  modport source (output valid, output reference_sample, output mic_sample, input ready);
  modport sink   (input valid, input reference_sample, input mic_sample, output ready);
endinterface

### src/lec_out_if.sv
// ----------------------------------------------------------------------------
// lec_out_if
// Result channel: one echo-reduced sample per request.
// ----------------------------------------------------------------------------
interface lec_out_if;
  import lec_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [LEC_SAMPLE_W-1:0] error_sample;

  modport source (output valid, output error_sample, input ready);
  modport sink   (input valid, input error_sample, output ready);
endinterface

### src/lec_ram.sv
// ----------------------------------------------------------------------------
// lec_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/lec_datapath.sv
// ----------------------------------------------------------------------------
// lec_datapath
// Reference ring, coefficient store, shared MAC and the LMS update pipe.
// ----------------------------------------------------------------------------
module lec_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  lec_pkg::lec_cmd_t                       cmd,
  output lec_pkg::lec_stat_t                      stat,
  input  logic [lec_pkg::LEC_STEP_W-1:0]          step_size,
  input  logic signed [lec_pkg::LEC_SAMPLE_W-1:0] reference_sample,
  input  logic signed [lec_pkg::LEC_SAMPLE_W-1:0] mic_sample,
  output logic signed [lec_pkg::LEC_SAMPLE_W-1:0] error_sample
);
  import lec_pkg::*;

  localparam int MUERR_W   = LEC_STEP_W + LEC_SAMPLE_W + 1;
  localparam int PROD_W    = MUERR_W + LEC_SAMPLE_W;
  localparam int ACC_W     = LEC_COEF_W + LEC_SAMPLE_W + LEC_ADDR_W;
  localparam int EST_SHIFT = 30;
  localparam int UPD_SHIFT = 16;
  localparam int EST_W     = ACC_W - EST_SHIFT;
  localparam int DIFF_W    = EST_W + 1;
  localparam int DELTA_W   = PROD_W - UPD_SHIFT;
  localparam int SUM_W     = ((DELTA_W > LEC_COEF_W) ? DELTA_W : LEC_COEF_W) + 1;

  localparam logic signed [ACC_W-1:0]  EST_ROUND = ACC_W'(1) << (EST_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] UPD_ROUND = PROD_W'(1) << (UPD_SHIFT - 1);

  localparam logic signed [DIFF_W-1:0] ERR_MAX = DIFF_W'((1 << (LEC_SAMPLE_W - 1)) - 1);
  localparam logic signed [DIFF_W-1:0] ERR_MIN = -DIFF_W'(1 << (LEC_SAMPLE_W - 1));
  localparam logic signed [SUM_W-1:0]  COEF_MAX = SUM_W'({1'b0, {(LEC_COEF_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0]  COEF_MIN =
    {{(SUM_W-LEC_COEF_W+1){1'b1}}, {(LEC_COEF_W-1){1'b0}}};

  // memories
  logic                    ring_we, coef_we;
  logic [LEC_ADDR_W-1:0]   ring_waddr, coef_waddr;
  logic [LEC_SAMPLE_W-1:0] ring_wdata, ring_rdata;
  logic [LEC_COEF_W-1:0]   coef_wdata, coef_rdata;

  // pipeline
  logic                    rd_est_q, rd_upd_q, mac_q, wr_q;
  logic [LEC_ADDR_W-1:0]   idx_q1, idx_q2;
  logic signed [LEC_COEF_W-1:0] coef_d;
  logic signed [PROD_W-1:0]     prod;
  logic signed [MUERR_W-1:0]    mul_a;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      acc_rnd;
  logic signed [EST_W-1:0]      est;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [LEC_SAMPLE_W-1:0] mic_q, err_q;
  logic signed [MUERR_W-1:0]    mu_err;
  logic signed [PROD_W-1:0]     prod_rnd;
  logic signed [DELTA_W-1:0]    delta;
  logic signed [SUM_W-1:0]      coef_sum;
  logic signed [LEC_COEF_W-1:0] coef_new;

  lec_ram #(.WIDTH(LEC_SAMPLE_W), .DEPTH(LEC_TAPS)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (cmd.slot),
    .rdata (ring_rdata)
  );

  lec_ram #(.WIDTH(LEC_COEF_W), .DEPTH(LEC_TAPS)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (cmd.tap),
    .rdata (coef_rdata)
  );

  assign ring_we    = cmd.clear | cmd.load;
  assign ring_waddr = cmd.clear ? cmd.tap : cmd.slot;
  assign ring_wdata = cmd.clear ? '0 : reference_sample;

  assign coef_we    = cmd.clear | wr_q;
  assign coef_waddr = cmd.clear ? cmd.tap : idx_q2;
  assign coef_wdata = cmd.clear ? '0 : coef_new;

  // shared multiplier: coefficient for the estimate, step*error for the update
  assign mul_a = rd_est_q ? MUERR_W'($signed(coef_rdata)) : mu_err;

  // floor after rounding is the upper part of the rounded sum
  assign acc_rnd  = acc + EST_ROUND;
  assign est      = acc_rnd[ACC_W-1:EST_SHIFT];
  assign diff     = DIFF_W'(mic_q) - DIFF_W'(est);

  assign prod_rnd = prod + UPD_ROUND;
  assign delta    = prod_rnd[PROD_W-1:UPD_SHIFT];
  assign coef_sum = SUM_W'(coef_d) + SUM_W'(delta);

  always_comb begin
    if (coef_sum > COEF_MAX) begin
      coef_new = COEF_MAX[LEC_COEF_W-1:0];
    end else if (coef_sum < COEF_MIN) begin
      coef_new = COEF_MIN[LEC_COEF_W-1:0];
    end else begin
      coef_new = coef_sum[LEC_COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_est_q <= 1'b0;
      rd_upd_q <= 1'b0;
      mac_q    <= 1'b0;
      wr_q     <= 1'b0;
    end else begin
      rd_est_q <= cmd.est_rd;
      rd_upd_q <= cmd.upd_rd;
      mac_q    <= rd_est_q;
      wr_q     <= rd_upd_q;
    end
  end

  always_ff @(posedge clk) begin
    idx_q1 <= cmd.tap;
    idx_q2 <= idx_q1;
    coef_d <= $signed(coef_rdata);
    prod   <= mul_a * $signed(ring_rdata);

    if (cmd.load) begin
      mic_q <= mic_sample;
      acc   <= '0;
    end else if (mac_q) begin
      acc <= acc + ACC_W'(prod);
    end

    if (cmd.err) begin
      if (diff > ERR_MAX) begin
        err_q <= ERR_MAX[LEC_SAMPLE_W-1:0];
      end else if (diff < ERR_MIN) begin
        err_q <= ERR_MIN[LEC_SAMPLE_W-1:0];
      end else begin
        err_q <= diff[LEC_SAMPLE_W-1:0];
      end
    end

    if (cmd.mu) begin
      mu_err <= $signed({1'b0, step_size}) * err_q;
    end
  end

  // rnd is folded into err: the estimate is a pure function of acc
  assign stat.pipe_busy = rd_est_q | rd_upd_q | mac_q | wr_q | cmd.rnd;
  assign error_sample   = err_q;

endmodule

### src/lec_ctrl.sv
// ----------------------------------------------------------------------------
// lec_ctrl
// Sequencer: clearing pass, estimate walk, error, update walk, pointer.
// ----------------------------------------------------------------------------
module lec_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lec_pkg::lec_cmd_t  cmd,
  input  lec_pkg::lec_stat_t stat
);
  import lec_pkg::*;

  lec_state_t            state, state_next;
  logic [LEC_ADDR_W-1:0] tap, tap_next;
  logic [LEC_ADDR_W-1:0] slot, slot_next;
  logic [LEC_ADDR_W-1:0] ptr, ptr_next;
  logic                  out_vld, out_vld_next;
  logic                  last_tap;
  logic [LEC_ADDR_W-1:0] slot_inc;

  assign last_tap = (tap == LEC_LAST_TAP);
  assign slot_inc = (slot == LEC_LAST_TAP) ? '0 : slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= LEC_CLEAR;
      tap     <= '0;
      slot    <= '0;
      ptr     <= '0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      tap     <= tap_next;
      slot    <= slot_next;
      ptr     <= ptr_next;
      out_vld <= out_vld_next;
    end
  end

  always_comb begin
    state_next   = state;
    tap_next     = tap;
    slot_next    = slot;
    ptr_next     = ptr;
    out_vld_next = out_vld & ~out_ready;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.tap      = tap;
    cmd.slot     = slot;

    case (state)
      LEC_CLEAR: begin
        cmd.clear = 1'b1;
        tap_next  = tap + 1'b1;
        if (last_tap) begin
          state_next = LEC_IDLE;
        end
      end
      LEC_IDLE: begin
        in_ready = 1'b1;
        cmd.slot = ptr;
        if (in_valid) begin
          cmd.load   = 1'b1;
          tap_next   = '0;
          slot_next  = ptr;
          state_next = LEC_EST;
        end
      end
      LEC_EST: begin
        cmd.est_rd = 1'b1;
        tap_next   = tap + 1'b1;
        slot_next  = slot_inc;
        if (last_tap) begin
          state_next = LEC_EST_WAIT;
        end
      end
      LEC_EST_WAIT: begin
        if (!stat.pipe_busy) begin
          state_next = LEC_RND;
        end
      end
      LEC_RND: begin
        cmd.rnd    = 1'b1;
        state_next = LEC_ERR;
      end
      LEC_ERR: begin
        // hold until the output register is free
        if (!out_vld || out_ready) begin
          cmd.err      = 1'b1;
          out_vld_next = 1'b1;
          state_next   = LEC_MU;
        end
      end
      LEC_MU: begin
        cmd.mu     = 1'b1;
        tap_next   = '0;
        slot_next  = ptr;
        state_next = LEC_UPD;
      end
      LEC_UPD: begin
        cmd.upd_rd = 1'b1;
        tap_next   = tap + 1'b1;
        slot_next  = slot_inc;
        if (last_tap) begin
          state_next = LEC_UPD_WAIT;
        end
      end
      LEC_UPD_WAIT: begin
        if (!stat.pipe_busy) begin
          ptr_next   = (ptr == LEC_LAST_TAP) ? '0 : ptr + 1'b1;
          state_next = LEC_IDLE;
        end
      end
      default: begin
        state_next = LEC_IDLE;
      end
    endcase
  end

  assign out_valid = out_vld;

endmodule

### src/lms_echo_canceller_unit.sv
// ----------------------------------------------------------------------------
// lms_echo_canceller_unit
// Per-sample LMS adaptive FIR echo canceller over LEC_TAPS taps (1024).
// Each request carries a far-end reference and a microphone sample and gives
// one saturated error sample. Requests are taken one at a time: a single
// multiply-accumulate unit walks the coefficient and ring memories once for
// the estimate and once for the update, one tap per cycle. The next request
// is accepted while an earlier result still waits in the output register.
// After reset a clearing pass over all LEC_TAPS taps zeroes both memories;
// no request is accepted during it.
// step_size (Q0.16, reset 66) sits at byte address 0 of the APB-style port.
// ----------------------------------------------------------------------------
module lms_echo_canceller_unit (
  input  logic                            clk,
  input  logic                            rst,
  lec_in_if.sink                          samples,
  lec_out_if.source                       errors,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lec_pkg::LEC_PADDR_W-1:0] paddr,
  input  logic [lec_pkg::LEC_DATA_W-1:0]  pwdata,
  output logic [lec_pkg::LEC_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import lec_pkg::*;

  logic [LEC_STEP_W-1:0] step_size;
  logic                  reg_hit;
  lec_cmd_t              cmd;
  lec_stat_t             stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[LEC_PADDR_W-1] == LEC_REG_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= LEC_STEP_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      step_size <= pwdata[LEC_STEP_W-1:0];
    end
  end

  assign prdata = reg_hit ? LEC_DATA_W'(step_size) : '0;

  lec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (errors.valid),
    .out_ready (errors.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lec_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .step_size        (step_size),
    .reference_sample (samples.reference_sample),
    .mic_sample       (samples.mic_sample),
    .error_sample     (errors.error_sample)
  );

  // one request in flight: ready drops right after an accept
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("request accepted while another is in flight");

  // a fresh result is never shown in the same cycle a request could enter
  a_result_not_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(errors.valid) |-> !samples.ready)
    else $error("result raised while idle");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !samples.ready && !errors.valid)
    else $error("block ready straight out of reset");

endmodule
